// File: sv/rps_pkg.sv
// Shared types and constants for the random permutation shuffle core.
// Used by rps_ctrl, rps_dpath and random_permutation_shuffle_core; no dependencies.
package rps_pkg;

  localparam int SZ_W      = 9;   // perm_size register width
  localparam int RV_W      = 31;  // random word width
  localparam int OUT_W     = 8;   // emitted position and value width
  localparam int DIV_STEPS = 31;  // one remainder bit per random-word bit
  localparam int CNT_W     = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [SZ_W-1:0] PERM_SIZE_RST = 9'd256;

  // Register index codes (paddr[2] selects the register slot).
  localparam logic REG_PERM_SIZE = 1'b0;

  typedef struct packed {
    logic load;      // capture a new item and set up the remainder
    logic div_step;  // one restoring remainder step
    logic rd;        // read both table entries
    logic wr_j;      // write the entry at the swap index
    logic wr_pos;    // write the entry at position and emit the result
  } cmd_t;

  typedef struct packed {
    logic div_last;  // the current remainder step is the final one
  } sts_t;

endpackage

// File: sv/rps_ctrl.sv
// Sequencer for the shuffle core: steps each item through remainder, read and writes.
// Depends on rps_pkg for the command and status structs.
module rps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rps_pkg::sts_t sts,
  output rps_pkg::cmd_t cmd,
  output logic          busy
);
  import rps_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_WR_J   = 3'd3;
  localparam logic [2:0] ST_WR_POS = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WR_J;
      end
      ST_WR_J: begin
        cmd.wr_j  = 1'b1;
        state_nxt = ST_WR_POS;
      end
      ST_WR_POS: begin
        cmd.wr_pos = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: sv/rps_dpath.sv
// Datapath of the shuffle core: remainder unit, permutation table with written marks,
// position counter and result register. Depends on rps_pkg.
module rps_dpath #(
  parameter int MAX_SIZE = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rps_pkg::cmd_t              cmd,
  output rps_pkg::sts_t              sts,
  input  logic                       cfg_clear,
  input  logic [rps_pkg::SZ_W-1:0]   perm_size,
  input  logic [rps_pkg::RV_W-1:0]   random_value,
  output logic                       out_valid,
  output logic [rps_pkg::OUT_W-1:0]  out_position,
  output logic [rps_pkg::OUT_W-1:0]  out_value,
  output logic                       out_last_of_perm
);
  import rps_pkg::*;

  // The size register is 9 bits, so no more than 511 entries are ever in use.
  localparam int EFF_MAX = (MAX_SIZE < 511) ? MAX_SIZE : 511;
  localparam int IDX_W   = $clog2(EFF_MAX);

  logic [IDX_W-1:0] mem [EFF_MAX];
  logic [EFF_MAX-1:0] mark_r;

  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] j_r;
  logic [SZ_W-1:0]  n_r;
  logic [SZ_W-1:0]  d_r;
  logic [SZ_W-1:0]  rem_r;
  logic [RV_W-1:0]  rv_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] q_pos_r;
  logic [IDX_W-1:0] q_j_r;
  logic             mk_pos_r;
  logic             mk_j_r;

  logic [SZ_W-1:0]  n_eff;
  logic             wrap;
  logic [SZ_W:0]    rem_sh;
  logic [SZ_W:0]    rem_sub;
  logic [SZ_W-1:0]  rem_nxt;
  logic [IDX_W-1:0] j_w;
  logic [IDX_W-1:0] v_pos;
  logic [IDX_W-1:0] v_j;
  logic             last;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  always_comb begin
    n_eff = perm_size;
    if (perm_size == '0) begin
      n_eff = SZ_W'(1);
    end else if (perm_size > SZ_W'(EFF_MAX)) begin
      n_eff = SZ_W'(EFF_MAX);
    end
  end

  // A stale position past the current size starts a fresh permutation.
  assign wrap = (SZ_W'(pos_r) >= n_eff);

  // Restoring remainder step: bring in the next random bit, subtract if it fits.
  assign rem_sh  = {rem_r, rv_r[RV_W-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign rem_nxt = (rem_sh >= {1'b0, d_r}) ? rem_sub[SZ_W-1:0] : rem_sh[SZ_W-1:0];

  assign sts.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  assign j_w   = IDX_W'(SZ_W'(pos_r) + rem_r);
  assign v_pos = mk_pos_r ? q_pos_r : pos_r;
  assign v_j   = mk_j_r ? q_j_r : j_r;
  assign last  = (SZ_W'(pos_r) == (n_r - SZ_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rv_r  <= random_value;
      n_r   <= n_eff;
      d_r   <= n_eff - (wrap ? '0 : SZ_W'(pos_r));
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rv_r  <= {rv_r[RV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.rd) begin
      j_r <= j_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cfg_clear) begin
      pos_r <= '0;
    end else if (cmd.load && wrap) begin
      pos_r <= '0;
    end else if (cmd.wr_pos) begin
      pos_r <= last ? '0 : pos_r + IDX_W'(1);
    end
  end

  // Marks clear all at once; a clear beats the mark set by the final write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
    end else if (cfg_clear || (cmd.load && wrap) || (cmd.wr_pos && last)) begin
      mark_r <= '0;
    end else if (cmd.wr_j) begin
      mark_r[j_r] <= 1'b1;
    end else if (cmd.wr_pos) begin
      mark_r[pos_r] <= 1'b1;
    end
  end

  assign mem_we    = cmd.wr_j | cmd.wr_pos;
  assign mem_waddr = cmd.wr_j ? j_r : pos_r;
  assign mem_wdata = cmd.wr_j ? v_pos : v_j;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      q_pos_r  <= mem[pos_r];
      q_j_r    <= mem[j_w];
      mk_pos_r <= mark_r[pos_r];
      mk_j_r   <= mark_r[j_w];
    end
  end

  logic             out_valid_r;
  logic [OUT_W-1:0] out_position_r;
  logic [OUT_W-1:0] out_value_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.wr_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pos) begin
      out_position_r <= OUT_W'(pos_r);
      out_value_r    <= OUT_W'(v_j);
      out_last_r     <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_value        = out_value_r;
  assign out_last_of_perm = out_last_r;

endmodule

// File: sv/random_permutation_shuffle_core.sv
// Forward Fisher-Yates shuffle core: one random word in, one permutation element out.
// Each item runs through the bit-serial remainder unit, then one table read and two
// table writes; out_valid is registered from the final write. start is taken only
// while busy is low, so a new item is not taken until the last one's writes are done.
// Synchronous active-low reset clears position and written marks and sets perm_size
// to 256; the table needs no fill. Results cannot be stalled.
module random_permutation_shuffle_core #(
  parameter int MAX_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rps_pkg::RV_W-1:0]      in_random_value,
  output logic                          out_valid,
  output logic [rps_pkg::OUT_W-1:0]     out_position,
  output logic [rps_pkg::OUT_W-1:0]     out_value,
  output logic                          out_last_of_perm,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rps_pkg::PADDR_W-1:0]   paddr,
  input  logic [rps_pkg::PDATA_W-1:0]   pwdata,
  output logic [rps_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import rps_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [SZ_W-1:0] perm_size_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_PERM_SIZE);

  // Any size write abandons the permutation in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_size_r <= PERM_SIZE_RST;
    end else if (cfg_wr) begin
      perm_size_r <= pwdata[SZ_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PERM_SIZE) begin
      prdata = PDATA_W'(perm_size_r);
    end
  end

  rps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rps_dpath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_clear        (cfg_wr),
    .perm_size        (perm_size_r),
    .random_value     (in_random_value),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_value        (out_value),
    .out_last_of_perm (out_last_of_perm)
  );

endmodule
